FILE: rtl/trbp_pkg.sv
`timescale 1ns / 1ps
// shared sizes, request codes and status codes of the typed buffer pool
// no dependencies; used by trbp_ram users and the top level

package trbp_pkg;

    // pool geometry
    localparam int SLOTS_PER_CLASS = 16;
    localparam int REF_LIMIT       = 255;
    localparam int NUM_CLASSES     = 4;
    localparam int TOTAL_SLOTS     = NUM_CLASSES * SLOTS_PER_CLASS;

    // derived widths
    localparam int CLASS_W = 2;
    localparam int IDX_W   = (SLOTS_PER_CLASS > 1) ? $clog2(SLOTS_PER_CLASS) : 1;
    localparam int FC_W    = $clog2(SLOTS_PER_CLASS + 1);
    localparam int SA_W    = $clog2(TOTAL_SLOTS);
    localparam int CNT_W   = $clog2(REF_LIMIT + 1);

    // request codes
    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_ADD     = 2'd2;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_BAD_CLASS = 3'd2,
        ST_NOT_ALLOC = 3'd3,
        ST_SATURATED = 3'd4,
        ST_NULL      = 3'd5
    } status_t;

endpackage

FILE: rtl/trbp_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies

module trbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/typed_refcounted_buffer_pool.sv
`timescale 1ns / 1ps
// typed reference-counted buffer pool: per-class lifo free stacks and slot counts
// depends on trbp_pkg and trbp_ram
// a request taken while idle reads the stack and count memories, and the execute state
// writes them back and registers the result strobe (done); busy holds off a new request
// until the execute state is over; results cannot be stalled
// reset: free stacks and counts take their reset contents at once through per-entry
// valid flags, so a request can be taken as soon as reset is released

module typed_refcounted_buffer_pool (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] req_type,
    input  logic [2:0] buf_class,
    input  logic       has_handle,
    input  logic [5:0] slot_id,
    output logic       done,
    output logic [2:0] status,
    output logic [5:0] granted_slot,
    output logic [7:0] count_after,
    output logic       returned_to_pool
);

    localparam int S = trbp_pkg::SLOTS_PER_CLASS;
    localparam int T = trbp_pkg::TOTAL_SLOTS;
    localparam int IDX_W = trbp_pkg::IDX_W;
    localparam int FC_W = trbp_pkg::FC_W;
    localparam int SA_W = trbp_pkg::SA_W;
    localparam int CNT_W = trbp_pkg::CNT_W;
    localparam int CLASS_W = trbp_pkg::CLASS_W;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_RELEASE,
        OP_ADD,
        OP_NULL
    } op_t;

    state_t state_reg;
    logic   done_reg;
    trbp_pkg::status_t status_reg, status_next;
    logic [5:0] granted_reg, granted_next;
    logic [7:0] count_reg, count_next;
    logic       returned_reg, returned_next;
    logic [FC_W-1:0] free_count_reg [trbp_pkg::NUM_CLASSES];
    logic [FC_W-1:0] free_count_next [trbp_pkg::NUM_CLASSES];
    logic [T-1:0] stk_vld_reg;
    logic [T-1:0] ref_vld_reg;

    // request captured at the transfer
    op_t                op_reg;
    logic               class_ok_reg;
    logic               empty_reg;
    logic               sid_ok_reg;
    logic [CLASS_W-1:0] acls_reg;
    logic [IDX_W-1:0]   top_reg;
    logic [CLASS_W-1:0] rcls_reg;
    logic [IDX_W-1:0]   ridx_reg;
    logic [SA_W-1:0]    ref_addr_reg;
    logic               stk_vq_reg;
    logic               ref_vq_reg;

    // accept-side decode
    logic               accept;
    op_t                op_in;
    logic [CLASS_W-1:0] acls_in;
    logic [FC_W-1:0]    fc_in;
    logic [IDX_W-1:0]   top_in;
    logic [CLASS_W-1:0] rcls_in;
    logic [IDX_W-1:0]   ridx_in;
    logic [SA_W-1:0]    stk_raddr;
    logic [SA_W-1:0]    ref_raddr;

    // memory ports
    logic [IDX_W-1:0] stk_rdata;
    logic [CNT_W-1:0] ref_rdata;
    logic             stk_we;
    logic [SA_W-1:0]  stk_waddr;
    logic [IDX_W-1:0] stk_wdata;
    logic             ref_we;
    logic [SA_W-1:0]  ref_waddr;
    logic [CNT_W-1:0] ref_wdata;

    // execute-side values
    logic [IDX_W-1:0] stk_data;
    logic [CNT_W-1:0] ref_data;
    logic [SA_W-1:0]  alloc_slot;
    logic [SA_W-1:0]  push_addr;
    logic [CNT_W-1:0] cnt_dec;
    logic [CNT_W-1:0] cnt_inc;

    assign busy   = (state_reg == S_EXEC);
    assign accept = start && !busy;

    // decode the request and form the memory read addresses
    always_comb
    begin
        acls_in = buf_class[CLASS_W-1:0];
        fc_in   = free_count_reg[acls_in];
        top_in  = IDX_W'(fc_in - FC_W'(1));
        rcls_in = '0;
        for (int c = 1; c < trbp_pkg::NUM_CLASSES; c++)
        begin
            if (int'(slot_id) >= c * S)
            begin
                rcls_in = CLASS_W'(c);
            end
        end
        ridx_in   = IDX_W'(int'(slot_id) - int'(rcls_in) * S);
        stk_raddr = SA_W'(int'(acls_in) * S + int'(top_in));
        ref_raddr = SA_W'(slot_id);
        if (req_type == trbp_pkg::REQ_ALLOC)
        begin
            op_in = OP_ALLOC;
        end
        else if (req_type == trbp_pkg::REQ_RELEASE && has_handle)
        begin
            op_in = OP_RELEASE;
        end
        else if (req_type == trbp_pkg::REQ_ADD && has_handle)
        begin
            op_in = OP_ADD;
        end
        else
        begin
            op_in = OP_NULL;
        end
    end

    // capture the decoded request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= op_in;
            class_ok_reg <= (int'(buf_class) < trbp_pkg::NUM_CLASSES);
            empty_reg    <= (fc_in == '0);
            sid_ok_reg   <= (int'(slot_id) < T);
            acls_reg     <= acls_in;
            top_reg      <= top_in;
            rcls_reg     <= rcls_in;
            ridx_reg     <= ridx_in;
            ref_addr_reg <= ref_raddr;
            stk_vq_reg   <= stk_vld_reg[stk_raddr];
            ref_vq_reg   <= ref_vld_reg[ref_raddr];
        end
    end

    // free stacks of all classes
    trbp_ram #(
        .WIDTH (IDX_W),
        .DEPTH (T)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // reference counts of all slots
    trbp_ram #(
        .WIDTH (CNT_W),
        .DEPTH (T)
    ) u_count_ram (
        .clk   (clk),
        .we    (ref_we),
        .waddr (ref_waddr),
        .wdata (ref_wdata),
        .raddr (ref_raddr),
        .rdata (ref_rdata)
    );

    // entries never written read as their reset contents
    assign stk_data   = stk_vq_reg ? stk_rdata : top_reg;
    assign ref_data   = ref_vq_reg ? ref_rdata : '0;
    assign alloc_slot = SA_W'(int'(acls_reg) * S + int'(stk_data));
    assign push_addr  = SA_W'(int'(rcls_reg) * S + int'(free_count_reg[rcls_reg]));
    assign cnt_dec    = ref_data - CNT_W'(1);
    assign cnt_inc    = ref_data + CNT_W'(1);

    // read-modify-write of stack, counts and free counters
    always_comb
    begin
        status_next   = trbp_pkg::ST_OK;
        granted_next  = '0;
        count_next    = '0;
        returned_next = 1'b0;
        stk_we        = 1'b0;
        stk_waddr     = push_addr;
        stk_wdata     = ridx_reg;
        ref_we        = 1'b0;
        ref_waddr     = ref_addr_reg;
        ref_wdata     = '0;
        for (int c = 0; c < trbp_pkg::NUM_CLASSES; c++)
        begin
            free_count_next[c] = free_count_reg[c];
        end
        case (op_reg)
            OP_ALLOC:
            begin
                if (!class_ok_reg)
                begin
                    status_next = trbp_pkg::ST_BAD_CLASS;
                end
                else if (empty_reg)
                begin
                    status_next = trbp_pkg::ST_EMPTY;
                end
                else
                begin
                    ref_we    = 1'b1;
                    ref_waddr = alloc_slot;
                    ref_wdata = CNT_W'(1);
                    free_count_next[acls_reg] = FC_W'(top_reg);
                    granted_next = 6'(alloc_slot);
                    count_next   = 8'd1;
                end
            end
            OP_RELEASE:
            begin
                if (!sid_ok_reg || ref_data == '0)
                begin
                    status_next = trbp_pkg::ST_NOT_ALLOC;
                end
                else
                begin
                    ref_we     = 1'b1;
                    ref_wdata  = cnt_dec;
                    count_next = 8'(cnt_dec);
                    if (cnt_dec == '0 && int'(free_count_reg[rcls_reg]) < S)
                    begin
                        stk_we        = 1'b1;
                        returned_next = 1'b1;
                        free_count_next[rcls_reg] = free_count_reg[rcls_reg] + FC_W'(1);
                    end
                end
            end
            OP_ADD:
            begin
                if (!sid_ok_reg || ref_data == '0)
                begin
                    status_next = trbp_pkg::ST_NOT_ALLOC;
                end
                else if (int'(ref_data) >= trbp_pkg::REF_LIMIT)
                begin
                    status_next = trbp_pkg::ST_SATURATED;
                    count_next  = 8'(ref_data);
                end
                else
                begin
                    ref_we     = 1'b1;
                    ref_wdata  = cnt_inc;
                    count_next = 8'(cnt_inc);
                end
            end
            default:
            begin
                status_next = trbp_pkg::ST_NULL;
            end
        endcase
        // memories are written back only in the execute cycle
        if (state_reg != S_EXEC)
        begin
            stk_we = 1'b0;
            ref_we = 1'b0;
        end
    end

    // sequencer, free counters, valid flags and registered results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            done_reg     <= 1'b0;
            status_reg   <= trbp_pkg::ST_OK;
            granted_reg  <= '0;
            count_reg    <= '0;
            returned_reg <= 1'b0;
            stk_vld_reg  <= '0;
            ref_vld_reg  <= '0;
            for (int c = 0; c < trbp_pkg::NUM_CLASSES; c++)
            begin
                free_count_reg[c] <= FC_W'(S);
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    state_reg    <= S_IDLE;
                    done_reg     <= 1'b1;
                    status_reg   <= status_next;
                    granted_reg  <= granted_next;
                    count_reg    <= count_next;
                    returned_reg <= returned_next;
                    for (int c = 0; c < trbp_pkg::NUM_CLASSES; c++)
                    begin
                        free_count_reg[c] <= free_count_next[c];
                    end
                    if (stk_we)
                    begin
                        stk_vld_reg[stk_waddr] <= 1'b1;
                    end
                    if (ref_we)
                    begin
                        ref_vld_reg[ref_waddr] <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    done_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign done             = done_reg;
    assign status           = status_reg;
    assign granted_slot     = granted_reg;
    assign count_after      = count_reg;
    assign returned_to_pool = returned_reg;

    // a transfer always enters the execute state, which leads to exactly one result strobe
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request transfer did not enter execution");

    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done && !busy)
        else $error("execution cycle did not produce a result strobe");

    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_return_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && returned_to_pool |-> status == trbp_pkg::ST_OK && count_after == 8'd0)
        else $error("slot returned to pool with a nonzero count");

    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != trbp_pkg::ST_OK |-> granted_slot == 6'd0 && !returned_to_pool)
        else $error("failed request granted or returned a slot");

endmodule
